### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; take in by include before use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// concurrent assertion on the house clock and reset names
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/pmvtg_pkg.sv
// package for the pal mono video timing generator
// types, codes and reset constants; no dependencies
package pmvtg_pkg;

  localparam int LinesPerFieldDef = 304;
  localparam int BlankLinesDef    = 20;
  localparam int BytesPerLineDef  = 30;

  localparam int LongSyncCount  = 5;
  localparam int ShortSyncCount = 5;
  localparam int TrailSyncCount = 6;

  localparam int RegW    = 16;
  localparam int IdxW    = 3;
  localparam int AddrInW = 14;
  localparam int DataW   = 8;
  localparam int LineW   = 9;

  localparam logic [DataW-1:0] StoreFill = 8'h0A;

  localparam logic [RegW-1:0] FrontPorchRst = 16'd159;
  localparam logic [RegW-1:0] HsyncRst      = 16'd452;
  localparam logic [RegW-1:0] BackPorchRst  = 16'd96;
  localparam logic [RegW-1:0] LinePeriodRst = 16'd6192;
  localparam logic [RegW-1:0] HalfLineRst   = 16'd3096;
  localparam logic [RegW-1:0] LongLowRst    = 16'd2621;
  localparam logic [RegW-1:0] ShortLowRst   = 16'd240;
  localparam logic [RegW-1:0] BitTicksRst   = 16'd23;

  typedef enum logic [IdxW-1:0] {
    REG_FRONT_PORCH = 3'd0,
    REG_HSYNC       = 3'd1,
    REG_BACK_PORCH  = 3'd2,
    REG_LINE_PERIOD = 3'd3,
    REG_HALF_LINE   = 3'd4,
    REG_LONG_LOW    = 3'd5,
    REG_SHORT_LOW   = 3'd6,
    REG_BIT_TICKS   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LVL_LOW   = 2'd0,
    LVL_BLACK = 2'd1,
    LVL_WHITE = 2'd2
  } level_e;

  typedef enum logic [1:0] {
    PH_LONG  = 2'd0,
    PH_SHORT = 2'd1,
    PH_VIDEO = 2'd2,
    PH_TRAIL = 2'd3
  } phase_e;

  // one tick on its way from the state update to the output register
  typedef struct packed {
    logic             pixel;    // level comes from the store byte
    level_e           lvl;      // level when not a pixel
    logic [2:0]       bit_sel;
    phase_e           phase;
    logic [LineW-1:0] line;
  } tick_info_t;

endpackage

### hw/rtl/pmvtg_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pmvtg_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pal_mono_video_timing_generator_top.sv
// top level of the pal mono video timing generator
// uses pmvtg_pkg and pmvtg_ram (frame store)
//
// usage
// - input channel (in_valid_i / in_ready_o): each beat is a command. cmd_i = 0 is one
//   time tick and yields one result beat; cmd_i = 1 writes write_data_i into the
//   frame store at write_address_i (addresses past the store are dropped) and
//   yields nothing
// - output channel (out_valid_o / out_ready_i): level, phase and line number of
//   one tick, in tick order
// - config channel (cfg_valid_i / cfg_ready_o): always ready, index 0..7 selects
//   the timing register; write only while no tick is in flight
// - throughput: one beat per cycle while the result side does not stall; a tick
//   passes the state update and store read, then level select into the output reg
// - stall: a waiting result sits in the output register; one more tick is taken
//   into the read stage, after that in_ready_o drops until out_ready_i returns
// - reset: timing registers take their defaults, the field restarts at the first
//   long sync, and the frame store is swept to 0x0a one byte per cycle over all
//   STORE_DEPTH bytes (8520 at defaults); in_ready_o stays low until done
module pal_mono_video_timing_generator_top
  import pmvtg_pkg::*;
#(
  parameter int LINES_PER_FIELD = LinesPerFieldDef,
  parameter int BLANK_LINES     = BlankLinesDef,
  parameter int BYTES_PER_LINE  = BytesPerLineDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [AddrInW-1:0] write_address_i,
  input  logic [DataW-1:0]   write_data_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         level_o,
  output logic [1:0]         phase_o,
  output logic [LineW-1:0]   line_number_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IdxW-1:0]    cfg_index_i,
  input  logic [RegW-1:0]    cfg_data_i
);

  localparam int ShownLines = (LINES_PER_FIELD > BLANK_LINES) ?
                              (LINES_PER_FIELD - BLANK_LINES) : 1;
  localparam int StoreDepth = ShownLines * BYTES_PER_LINE;
  localparam int AW         = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int BW         = $clog2(BYTES_PER_LINE + 1);
  // wide enough for any store address and any write address
  localparam int SAW        = 17;

  localparam logic [SAW-1:0]   StoreDepthW = SAW'(StoreDepth);
  localparam logic [AW-1:0]    LastAddr    = AW'(StoreDepth - 1);
  localparam logic [LineW-1:0] BlankW      = LineW'(BLANK_LINES);
  localparam logic [BW-1:0]    BytesW      = BW'(BYTES_PER_LINE);
  localparam logic [LineW:0]   LinesW      = (LineW + 1)'(LINES_PER_FIELD);
  localparam logic [LineW:0]   LongCntW    = (LineW + 1)'(LongSyncCount);
  localparam logic [LineW:0]   ShortCntW   = (LineW + 1)'(ShortSyncCount);
  localparam logic [LineW:0]   TrailCntW   = (LineW + 1)'(TrailSyncCount);

  // ---------------------------------------------------------------- registers
  logic [RegW-1:0] fp_q, hs_q, bp_q, lp_q, hl_q, ll_q, sl_q, bt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= FrontPorchRst;
      hs_q <= HsyncRst;
      bp_q <= BackPorchRst;
      lp_q <= LinePeriodRst;
      hl_q <= HalfLineRst;
      ll_q <= LongLowRst;
      sl_q <= ShortLowRst;
      bt_q <= BitTicksRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRONT_PORCH: fp_q <= cfg_data_i;
        REG_HSYNC:       hs_q <= cfg_data_i;
        REG_BACK_PORCH:  bp_q <= cfg_data_i;
        REG_LINE_PERIOD: lp_q <= cfg_data_i;
        REG_HALF_LINE:   hl_q <= cfg_data_i;
        REG_LONG_LOW:    ll_q <= cfg_data_i;
        REG_SHORT_LOW:   sl_q <= cfg_data_i;
        REG_BIT_TICKS:   bt_q <= cfg_data_i;
        default:         fp_q <= fp_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s1_free;
  logic in_acc, tick_acc, wr_acc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_ready_o = s1_free && !clr_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && !cmd_i;
  assign wr_acc     = in_acc && cmd_i;

  // ---------------------------------------------------------------- timing state
  phase_e           ph_q, ph_d;
  logic [RegW-1:0]  tick_q, tick_d;
  logic [LineW-1:0] line_q, line_d;
  logic [RegW-1:0]  bcnt_q, bcnt_d;
  logic [2:0]       bidx_q, bidx_d;
  logic [BW-1:0]    byte_q, byte_d;

  tick_info_t      info_d, s1_info_q;
  logic [SAW-1:0]  rd_addr_full;
  logic [AW-1:0]   rd_addr;

  // boundaries summed wide so nothing wraps
  logic [RegW+1:0] fp_end, hs_end, pix_start, tick_w;
  logic [RegW:0]   tick_inc, bcnt_inc, period, bit_per;
  logic [RegW-1:0] low_ticks;
  logic [LineW:0]  line_inc, count;
  logic [LineW-1:0] line_off;
  logic            in_pix, pix_adv;

  always_comb begin
    fp_end    = {2'b00, fp_q};
    hs_end    = fp_end + {2'b00, hs_q};
    pix_start = hs_end + {2'b00, bp_q};
    tick_w    = {2'b00, tick_q};
    tick_inc  = {1'b0, tick_q} + 17'd1;
    bcnt_inc  = {1'b0, bcnt_q} + 17'd1;
    bit_per   = (bt_q == '0) ? 17'd1 : {1'b0, bt_q};
    line_inc  = {1'b0, line_q} + 10'd1;
    line_off  = line_q - BlankW;
    rd_addr_full = SAW'(line_off) * SAW'(BYTES_PER_LINE) + SAW'(byte_q);
    rd_addr   = rd_addr_full[AW-1:0];
    low_ticks = (ph_q == PH_LONG) ? ll_q : sl_q;

    in_pix  = (ph_q == PH_VIDEO) && (tick_w >= pix_start);
    pix_adv = in_pix && (line_q >= BlankW) && (byte_q < BytesW);

    info_d.pixel   = pix_adv && (rd_addr_full < StoreDepthW);
    info_d.bit_sel = bidx_q;
    info_d.phase   = ph_q;
    info_d.line    = line_q;
    if (ph_q == PH_VIDEO) begin
      if (tick_w < fp_end) begin
        info_d.lvl = LVL_BLACK;
      end else if (tick_w < hs_end) begin
        info_d.lvl = LVL_LOW;
      end else begin
        info_d.lvl = LVL_BLACK;
      end
    end else begin
      info_d.lvl = (tick_q < low_ticks) ? LVL_LOW : LVL_BLACK;
    end

    unique case (ph_q)
      PH_LONG:  count = LongCntW;
      PH_SHORT: count = ShortCntW;
      PH_VIDEO: count = LinesW;
      PH_TRAIL: count = TrailCntW;
      default:  count = LinesW;
    endcase
    period = (ph_q == PH_VIDEO) ? ((lp_q == '0) ? 17'd1 : {1'b0, lp_q})
                                : ((hl_q == '0) ? 17'd1 : {1'b0, hl_q});

    ph_d   = ph_q;
    tick_d = tick_q;
    line_d = line_q;
    bcnt_d = bcnt_q;
    bidx_d = bidx_q;
    byte_d = byte_q;

    // pixel clock advance
    if (pix_adv) begin
      if (bcnt_inc >= bit_per) begin
        bcnt_d = '0;
        bidx_d = bidx_q + 3'd1;
        if (bidx_q == 3'd7) begin
          byte_d = byte_q + BW'(1);
        end
      end else begin
        bcnt_d = bcnt_inc[RegW-1:0];
      end
    end

    // end of line or half-line
    if (tick_inc >= period) begin
      tick_d = '0;
      bcnt_d = '0;
      bidx_d = '0;
      byte_d = '0;
      if (line_inc >= count) begin
        line_d = '0;
        ph_d   = phase_e'(ph_q + 2'd1);
      end else begin
        line_d = line_inc[LineW-1:0];
      end
    end else begin
      tick_d = tick_inc[RegW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_LONG;
      tick_q <= '0;
      line_q <= '0;
      bcnt_q <= '0;
      bidx_q <= '0;
      byte_q <= '0;
    end else if (tick_acc) begin
      ph_q   <= ph_d;
      tick_q <= tick_d;
      line_q <= line_d;
      bcnt_q <= bcnt_d;
      bidx_q <= bidx_d;
      byte_q <= byte_d;
    end
  end

  // ---------------------------------------------------------------- frame store
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  logic [SAW-1:0]  wr_addr_full;

  assign wr_addr_full = SAW'(write_address_i);

  // clearing sweep owns the write port after reset
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = StoreFill;
    end else begin
      ram_we    = wr_acc && (wr_addr_full < StoreDepthW);
      ram_waddr = wr_addr_full[AW-1:0];
      ram_wdata = write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  pmvtg_ram #(
    .Width (DataW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (tick_acc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- read stage
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (tick_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_info_q <= info_d;
    end
  end

  // ---------------------------------------------------------------- output register
  level_e           lvl_sel;
  logic [1:0]       level_q;
  logic [1:0]       phase_out_q;
  logic [LineW-1:0] line_out_q;

  // pixel bit of the store byte picks white or black
  always_comb begin
    if (s1_info_q.pixel) begin
      lvl_sel = ram_rdata[s1_info_q.bit_sel] ? LVL_WHITE : LVL_BLACK;
    end else begin
      lvl_sel = s1_info_q.lvl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      level_q     <= lvl_sel;
      phase_out_q <= s1_info_q.phase;
      line_out_q  <= s1_info_q.line;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign phase_o       = phase_out_q;
  assign line_number_o = line_out_q;

endmodule

### hw/rtl/pmvtg_checker.sv
// port-level checker for the pal mono video timing generator, with its bind
// uses pmvtg_pkg and assert_macros.svh
`include "assert_macros.svh"

module pmvtg_checker
  import pmvtg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       level_o,
  input logic [1:0]       phase_o,
  input logic [LineW-1:0] line_number_o
);

  logic out_stall, sync_beat, trail_beat, other_beat;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign sync_beat  = out_valid_o && (phase_o == PH_LONG || phase_o == PH_SHORT);
  assign trail_beat = out_valid_o && phase_o == PH_TRAIL;
  assign other_beat = out_valid_o && phase_o != PH_VIDEO;

  // a stalled result stays put
  `ASSERT_STD(a_out_hold, out_stall |=> out_valid_o && $stable(level_o), "result dropped")

  // level code three is never produced
  `ASSERT_STD(a_level_code, out_valid_o |-> level_o != 2'd3, "bad level code")

  // sync half-lines carry no pixels
  `ASSERT_STD(a_sync_no_white, other_beat |-> level_o != LVL_WHITE, "white in sync")

  // sync phases count only their few half-lines
  `ASSERT_STD(a_sync_count, sync_beat |-> line_number_o < 9'd5, "sync count overrun")

  `ASSERT_STD(a_trail_count, trail_beat |-> line_number_o < 9'd6, "trailing sync overrun")

endmodule

bind pal_mono_video_timing_generator_top pmvtg_checker u_pmvtg_checker (.*);

### verif/pmvtg_level_checker.sv
// result checker for the pal mono video timing generator
// watches the command, result and register channels and predicts every tick
// depends on pmvtg_pkg
module pmvtg_level_checker
  import pmvtg_pkg::*;
#(
  parameter logic CmdWrite = 1'b1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic [AddrInW-1:0] write_address_i,
  input  logic [DataW-1:0]   write_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         level_i,
  input  logic [1:0]         phase_i,
  input  logic [LineW-1:0]   line_number_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [IdxW-1:0]    cfg_index_i,
  input  logic [RegW-1:0]    cfg_data_i,
  output logic [31:0]        fail_count_o,
  output logic [31:0]        pending_o
);

  localparam int ShownLines = (LinesPerFieldDef > BlankLinesDef) ?
                              (LinesPerFieldDef - BlankLinesDef) : 1;
  localparam int StoreDepth = ShownLines * BytesPerLineDef;
  localparam int ReportMax  = 10;

  typedef struct packed {
    level_e           lvl;
    phase_e           phase;
    logic [LineW-1:0] line;
  } tick_out_t;

  logic [RegW-1:0]  timing_q [8];
  logic [DataW-1:0] pixels_q [StoreDepth];
  phase_e           phase_q;
  logic [15:0]      tick_q;
  logic [LineW-1:0] line_q;
  logic [15:0]      bit_cnt_q;
  logic [2:0]       bit_sel_q;
  logic [4:0]       byte_sel_q;
  tick_out_t        levels_due [$];
  int unsigned      fails = 0;

  function automatic int unsigned nonzero(input logic [RegW-1:0] v);
    return (v == '0) ? 1 : v;
  endfunction

  // level of the next tick, then step the line timing
  function automatic tick_out_t predict_level();
    tick_out_t   o;
    int unsigned fp_end, hs_end, pix_start, period, count, low_end, addr;
    logic [1:0]  ph_next;
    o.lvl   = LVL_BLACK;
    o.phase = phase_q;
    o.line  = line_q;
    if (phase_q == PH_VIDEO) begin
      // boundaries are 32-bit sums, so they never wrap
      fp_end    = timing_q[REG_FRONT_PORCH];
      hs_end    = fp_end + timing_q[REG_HSYNC];
      pix_start = hs_end + timing_q[REG_BACK_PORCH];
      if (tick_q < fp_end) begin
        o.lvl = LVL_BLACK;
      end else if (tick_q < hs_end) begin
        o.lvl = LVL_LOW;
      end else if (tick_q >= pix_start && line_q >= BlankLinesDef &&
                   byte_sel_q < BytesPerLineDef) begin
        addr = (line_q - BlankLinesDef) * BytesPerLineDef + byte_sel_q;
        if (addr < StoreDepth && pixels_q[addr][bit_sel_q]) o.lvl = LVL_WHITE;
        bit_cnt_q++;
        if (bit_cnt_q >= nonzero(timing_q[REG_BIT_TICKS])) begin
          bit_cnt_q = '0;
          bit_sel_q++;
          if (bit_sel_q == '0) byte_sel_q++;
        end
      end
      period = nonzero(timing_q[REG_LINE_PERIOD]);
      count  = LinesPerFieldDef;
    end else begin
      low_end = (phase_q == PH_LONG) ? timing_q[REG_LONG_LOW] : timing_q[REG_SHORT_LOW];
      o.lvl   = (tick_q < low_end) ? LVL_LOW : LVL_BLACK;
      period  = nonzero(timing_q[REG_HALF_LINE]);
      count   = (phase_q == PH_LONG)  ? LongSyncCount :
                (phase_q == PH_SHORT) ? ShortSyncCount : TrailSyncCount;
    end
    if (tick_q + 1 >= period) begin
      tick_q     = '0;
      bit_cnt_q  = '0;
      bit_sel_q  = '0;
      byte_sel_q = '0;
      line_q++;
      if (line_q >= count) begin
        line_q  = '0;
        ph_next = phase_q + 2'd1;
        phase_q = phase_e'(ph_next);
      end
    end else begin
      tick_q++;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_out_t got, want;
    if (!rst_ni) begin
      timing_q[REG_FRONT_PORCH] = FrontPorchRst;
      timing_q[REG_HSYNC]       = HsyncRst;
      timing_q[REG_BACK_PORCH]  = BackPorchRst;
      timing_q[REG_LINE_PERIOD] = LinePeriodRst;
      timing_q[REG_HALF_LINE]   = HalfLineRst;
      timing_q[REG_LONG_LOW]    = LongLowRst;
      timing_q[REG_SHORT_LOW]   = ShortLowRst;
      timing_q[REG_BIT_TICKS]   = BitTicksRst;
      for (int i = 0; i < StoreDepth; i++) pixels_q[i] = StoreFill;
      phase_q    = PH_LONG;
      tick_q     = '0;
      line_q     = '0;
      bit_cnt_q  = '0;
      bit_sel_q  = '0;
      byte_sel_q = '0;
      levels_due.delete();
      pending_o    <= '0;
      fail_count_o <= fails;
    end else begin
      // results first: a tick taken on this edge cannot have come out yet
      if (out_valid_i && out_ready_i) begin
        got.lvl   = level_e'(level_i);
        got.phase = phase_e'(phase_i);
        got.line  = line_number_i;
        if (levels_due.size() == 0) begin
          if (fails < ReportMax)
            $display("%0t: unexpected result beat: level %0d phase %0d line %0d",
                     $time, level_i, phase_i, line_number_i);
          fails++;
        end else begin
          want = levels_due.pop_front();
          if (got != want) begin
            if (fails < ReportMax)
              $display("%0t: mismatch: level %0d (exp %0d) phase %0d (exp %0d) line %0d (exp %0d)",
                       $time, got.lvl, want.lvl, got.phase, want.phase, got.line, want.line);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) timing_q[cfg_index_i] = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CmdWrite) begin
          if (write_address_i < StoreDepth) pixels_q[write_address_i] = write_data_i;
        end else begin
          levels_due.push_back(predict_level());
        end
      end
      pending_o    <= levels_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

### verif/tb.sv
// testbench top for the pal mono video timing generator
// drives commands and register writes, stalls the result side, gives the verdict
// depends on pmvtg_pkg, pal_mono_video_timing_generator_top and pmvtg_level_checker
module tb;
  import pmvtg_pkg::*;

  // command codes of the input beat
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 8;
  // pipeline drain plus margin; also covers a write still in flight
  localparam int SettleCycles = 8;
  // store sweep after reset, ~1000 beats at worst stall and gap, ten times over
  localparam int LimitCycles  = 400000;
  localparam int AddrMax      = (1 << AddrInW) - 1;

  // one full set of timing registers
  typedef struct packed {
    logic [RegW-1:0] front_porch;
    logic [RegW-1:0] hsync;
    logic [RegW-1:0] back_porch;
    logic [RegW-1:0] line_period;
    logic [RegW-1:0] half_line;
    logic [RegW-1:0] long_low;
    logic [RegW-1:0] short_low;
    logic [RegW-1:0] bit_ticks;
  } timing_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic               cmd_i           = CmdTick;
  logic [AddrInW-1:0] write_address_i = '0;
  logic [DataW-1:0]   write_data_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [1:0]         level_o;
  logic [1:0]         phase_o;
  logic [LineW-1:0]   line_number_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [IdxW-1:0]    cfg_index_i     = '0;
  logic [RegW-1:0]    cfg_data_i      = '0;

  logic [31:0]        fail_count;
  logic [31:0]        pending;

  // sender burst bookkeeping
  int unsigned        burst_left = 0;

  // receiver stall pattern, rotated every cycle and reloaded now and then
  logic [15:0]        ready_pattern = 16'hFFFF;
  int unsigned        pattern_age   = 0;

  pal_mono_video_timing_generator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .write_address_i (write_address_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .phase_o         (phase_o),
    .line_number_o   (line_number_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  pmvtg_level_checker #(.CmdWrite(CmdWrite)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .write_address_i (write_address_i),
    .write_data_i    (write_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_i         (level_o),
    .phase_i         (phase_o),
    .line_number_i   (line_number_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // result side: open stretches, random masks, a long half-duty stall and
  // single dropped cycles, each held for a random number of cycles
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      case ($urandom_range(3))
        0:       ready_pattern <= 16'hFFFF;
        1:       ready_pattern <= 16'($urandom_range(16'hFFFF, 1));
        2:       ready_pattern <= 16'h00FF;
        default: ready_pattern <= 16'hFFFF ^ (16'h1 << $urandom_range(15));
      endcase
      pattern_age <= $urandom_range(200, 20);
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_age   <= pattern_age - 1;
    end
    out_ready_i <= ready_pattern[0];
  end

  // store size as the block sees it
  function automatic int StoreDepth();
    return (LinesPerFieldDef - BlankLinesDef) * BytesPerLineDef;
  endfunction

  function automatic timing_t make_timing(
    input int fp, input int hs, input int bp, input int lp,
    input int half, input int long_l, input int short_l, input int bits
  );
    timing_t t;
    t.front_porch = RegW'(fp);
    t.hsync       = RegW'(hs);
    t.back_porch  = RegW'(bp);
    t.line_period = RegW'(lp);
    t.half_line   = RegW'(half);
    t.long_low    = RegW'(long_l);
    t.short_low   = RegW'(short_l);
    t.bit_ticks   = RegW'(bits);
    return t;
  endfunction

  // short lines and half-lines so that whole fields pass quickly
  function automatic timing_t random_small_timing();
    return make_timing($urandom_range(7), $urandom_range(7), $urandom_range(7),
                       $urandom_range(60), $urandom_range(8), $urandom_range(8),
                       $urandom_range(8), $urandom_range(3));
  endfunction

  // one command beat; starts a new burst after a random gap when the last ran out
  task automatic send_beat(
    input logic cmd, input logic [AddrInW-1:0] addr, input logic [DataW-1:0] data
  );
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(200, 50) : $urandom_range(24, 1);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    write_address_i <= addr;
    write_data_i    <= data;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
  endtask

  // a tick beat with random filler in the unused fields
  task automatic send_tick();
    send_beat(CmdTick, AddrInW'($urandom_range(AddrMax)), DataW'($urandom_range(255)));
  endtask

  // hold off until every result is out, then let the pipeline drain
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [RegW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_timing(input timing_t t);
    drain();
    write_reg(REG_FRONT_PORCH, t.front_porch);
    write_reg(REG_HSYNC,       t.hsync);
    write_reg(REG_BACK_PORCH,  t.back_porch);
    write_reg(REG_LINE_PERIOD, t.line_period);
    write_reg(REG_HALF_LINE,   t.half_line);
    write_reg(REG_LONG_LOW,    t.long_low);
    write_reg(REG_SHORT_LOW,   t.short_low);
    write_reg(REG_BIT_TICKS,   t.bit_ticks);
    cfg_valid_i <= 1'b0;
  endtask

  // ticks mixed with store writes; most writes land in addr_lo..addr_hi,
  // one in ten anywhere in the 14-bit range, past the store included
  task automatic run_mix(
    input int n_ticks, input int write_pct, input int addr_lo, input int addr_hi
  );
    int                 ticks_done;
    logic [AddrInW-1:0] addr;
    ticks_done = 0;
    while (ticks_done < n_ticks) begin
      if ($urandom_range(99) < write_pct) begin
        if ($urandom_range(9) == 0) addr = AddrInW'($urandom_range(AddrMax));
        else addr = AddrInW'($urandom_range(addr_hi, addr_lo));
        send_beat(CmdWrite, addr, DataW'($urandom_range(255)));
      end else begin
        send_tick();
        ticks_done++;
      end
    end
  endtask

  initial begin : stimulus
    timing_t t;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // store edges: first and last byte, just past the store, top of the address field
    send_beat(CmdWrite, 14'd0,    8'hFF);
    send_beat(CmdWrite, 14'd8519, 8'h00);
    send_beat(CmdWrite, 14'd8520, 8'h55);
    send_beat(CmdWrite, 14'd16383, 8'hAA);
    send_beat(CmdWrite, 14'd30,   8'h81);
    // default timing: inside the first long sync, all sync low
    repeat (4) send_tick();

    // all zero: periods and bit time act as one, and the tick count already
    // sits past the new period, so the half-line ends on the first tick;
    // ten ticks walk through long and short sync into video line 0
    program_timing('0);
    repeat (10) send_tick();

    // all ones: porch sums far past 16 bits
    program_timing('1);
    repeat (3) send_tick();

    // zero timing again: one tick per line, lines 20..24 show one pixel each
    program_timing('0);
    run_mix(25, 20, 0, 299);

    // porch sum overflows 16 bits: pixels must never start on lines 25..26
    program_timing(make_timing(1, 2, 65535, 8, 3, 1, 2, 1));
    run_mix(16, 20, 0, 299);

    // long line, no porches: all 30 bytes shown, then black once they run out
    program_timing(make_timing(0, 0, 0, 250, 3, 2, 1, 1));
    run_mix(250, 20, 150, 299);

    // a scaled-down real line with two ticks per pixel
    program_timing(make_timing(2, 3, 2, 40, 6, 4, 1, 2));
    run_mix(100, 15, 240, 600);

    // one tick per line: through the end of the field, trailing sync and
    // around into the next field
    program_timing(make_timing(0, 0, 0, 1, 1, 1, 0, 0));
    run_mix(300, 10, 0, StoreDepth() - 1);

    program_timing(random_small_timing());
    run_mix(50, 15, 0, StoreDepth() - 1);

    // every register bit at random
    t = {$urandom(), $urandom(), $urandom(), $urandom()};
    program_timing(t);
    run_mix(40, 15, 0, StoreDepth() - 1);

    program_timing(random_small_timing());
    run_mix(40, 30, 0, StoreDepth() - 1);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("pal_mono_video_timing_generator_top test passed");
    end else begin
      $display("pal_mono_video_timing_generator_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitCycles * 2 * ClkHalf);
    $display("pal_mono_video_timing_generator_top test failed");
    $finish;
  end

endmodule
